// ----- hw/rtl/sma_pkg.sv -----
// Shared types and constants for the sign-magnitude digit ALU.
package sma_pkg;

	localparam int MAG_BITS = 64;
	localparam int DIGIT_COUNT_DEF = 16;
	localparam int DIGIT_BITS_DEF = 4;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_CMP = 2'd3
	} op_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} stage_en_t;

endpackage

// ----- hw/rtl/sign_magnitude_digit_alu.sv -----
// Top level of the pipelined sign-magnitude digit ALU.
//
//   Channel | Handshake            | Payload
//   --------+----------------------+---------------------------------------------
//   input   | in_valid, in_stall   | op, a_magnitude, a_negative, b_magnitude,
//           |                      | b_negative
//   output  | out_valid, out_stall | result_magnitude, result_negative, overflow,
//           |                      | a_greater, a_less, a_equal
//
// The result of a request is registered through the four register stages in turn:
// operand capture, partial products and compare, product middle sum and add or
// subtract, and final selection.
// One request is accepted per cycle while the output is not stalled.
// Reset clears only the valid bits; the data registers are not reset.
// A stalled result stays put, and empty stages behind it still fill.
module sign_magnitude_digit_alu import sma_pkg::*; #(
	parameter int DIGIT_COUNT = DIGIT_COUNT_DEF,
	parameter int DIGIT_BITS  = DIGIT_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          op,
	input  logic [MAG_BITS-1:0] a_magnitude,
	input  logic                a_negative,
	input  logic [MAG_BITS-1:0] b_magnitude,
	input  logic                b_negative,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [MAG_BITS-1:0] result_magnitude,
	output logic                result_negative,
	output logic                overflow,
	output logic                a_greater,
	output logic                a_less,
	output logic                a_equal
);

	localparam int W = DIGIT_COUNT * DIGIT_BITS;

	stage_en_t    en;
	op_t          op_s1;
	logic [W-1:0] am_s1;
	logic         an_s1;
	logic [W-1:0] bm_s1;
	logic         bn_s1;
	op_t          op_s2;
	logic         xneg_s2;
	op_t          op_s3;
	logic         xneg_s3;
	logic [W-1:0] sum_mag_s3;
	logic         sum_neg_s3;
	logic         sum_ovf_s3;
	logic         gt_s3;
	logic         lt_s3;
	logic         eq_s3;
	logic [W-1:0] prod_lo;
	logic         prod_ovf;
	logic [W-1:0] res_mag_s4;
	logic         res_neg_s4;
	logic         ovf_s4;
	logic         gt_s4;
	logic         lt_s4;
	logic         eq_s4;

	sma_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.en        (en)
	);

	always_ff @(posedge clk) begin
		if (en.s1) begin
			op_s1 <= op_t'(op);
			am_s1 <= a_magnitude[W-1:0];
			an_s1 <= a_negative;
			bm_s1 <= b_magnitude[W-1:0];
			bn_s1 <= b_negative;
		end
		if (en.s2) begin
			op_s2   <= op_s1;
			xneg_s2 <= an_s1 ^ bn_s1;
		end
		if (en.s3) begin
			op_s3   <= op_s2;
			xneg_s3 <= xneg_s2;
		end
	end

	sma_mul #(
		.W (W)
	) u_mul (
		.clk      (clk),
		.en       (en),
		.a_s1     (am_s1),
		.b_s1     (bm_s1),
		.prod_lo  (prod_lo),
		.prod_ovf (prod_ovf)
	);

	sma_addsub #(
		.W (W)
	) u_addsub (
		.clk        (clk),
		.en         (en),
		.op_s1      (op_s1),
		.am_s1      (am_s1),
		.an_s1      (an_s1),
		.bm_s1      (bm_s1),
		.bn_s1      (bn_s1),
		.sum_mag_s3 (sum_mag_s3),
		.sum_neg_s3 (sum_neg_s3),
		.sum_ovf_s3 (sum_ovf_s3),
		.gt_s3      (gt_s3),
		.lt_s3      (lt_s3),
		.eq_s3      (eq_s3)
	);

	always_ff @(posedge clk) begin
		if (en.s4) begin
			gt_s4 <= gt_s3;
			lt_s4 <= lt_s3;
			eq_s4 <= eq_s3;
			unique case (op_s3)
				OP_ADD, OP_SUB: begin
					res_mag_s4 <= sum_mag_s3;
					res_neg_s4 <= sum_neg_s3 && (sum_mag_s3 != '0);
					ovf_s4     <= sum_ovf_s3;
				end
				OP_MUL: begin
					res_mag_s4 <= prod_lo;
					res_neg_s4 <= xneg_s3 && (prod_lo != '0);
					ovf_s4     <= prod_ovf;
				end
				OP_CMP: begin
					res_mag_s4 <= '0;
					res_neg_s4 <= 1'b0;
					ovf_s4     <= 1'b0;
				end
			endcase
		end
	end

	assign result_magnitude = MAG_BITS'(res_mag_s4);
	assign result_negative  = res_neg_s4;
	assign overflow         = ovf_s4;
	assign a_greater        = gt_s4;
	assign a_less           = lt_s4;
	assign a_equal          = eq_s4;

	// A zero result never carries a negative sign.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_negative |-> result_magnitude != '0)
		else $error("negative zero result");

	// Exactly one of the order flags is set on every result.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot({a_greater, a_less, a_equal}))
		else $error("order flags not exclusive");

	// Equal operands under subtract always give positive zero without overflow.
	assert property (@(posedge clk) disable iff (!arst_n)
		en.s4 && (op_s3 == OP_SUB) && eq_s3 |=> result_magnitude == '0 && !overflow)
		else $error("subtract of equal operands is not zero");

endmodule

// ----- hw/rtl/sma_ctrl.sv -----
// Valid bits and per-stage load enables of the four-stage pipeline.
module sma_ctrl import sma_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  logic      out_stall,
	output stage_en_t en
);

	logic v_s1;
	logic v_s2;
	logic v_s3;
	logic v_s4;

	always_comb begin
		en.s4 = !v_s4 || !out_stall;
		en.s3 = !v_s3 || en.s4;
		en.s2 = !v_s2 || en.s3;
		en.s1 = !v_s1 || en.s2;
	end

	assign in_stall  = !en.s1;
	assign out_valid = v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en.s1) begin
				v_s1 <= in_valid;
			end
			if (en.s2) begin
				v_s2 <= v_s1;
			end
			if (en.s3) begin
				v_s3 <= v_s2;
			end
			if (en.s4) begin
				v_s4 <= v_s3;
			end
		end
	end

	// An accepted request always occupies the first stage on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> v_s1)
		else $error("accepted request did not enter the first stage");

	// A stalled last stage must hold its request.
	assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && out_stall |=> v_s4)
		else $error("stalled result was dropped");

	// A full stage directly behind a stage that cannot advance is blocked as well.
	assert property (@(posedge clk) disable iff (!arst_n)
		!en.s3 && v_s2 |-> !en.s2)
		else $error("stage enables out of order");

endmodule

// ----- hw/rtl/sma_mul.sv -----
// Pipelined magnitude multiplier built from four half-width partial products.
module sma_mul import sma_pkg::*; #(
	parameter int W = DIGIT_COUNT_DEF * DIGIT_BITS_DEF
) (
	input  logic         clk,
	input  stage_en_t    en,
	input  logic [W-1:0] a_s1,
	input  logic [W-1:0] b_s1,
	output logic [W-1:0] prod_lo,
	output logic         prod_ovf
);

	localparam int LB = (W + 1) / 2;
	localparam int XW = 2 * LB;

	logic [XW-1:0] ax;
	logic [XW-1:0] bx;
	logic [XW-1:0] p00_s2;
	logic [XW-1:0] p01_s2;
	logic [XW-1:0] p10_s2;
	logic [XW-1:0] p11_s2;
	logic [LB+1:0] mid;
	logic [LB-1:0] lo_low_s3;
	logic [LB+1:0] mid_s3;
	logic          hi_any_s3;
	logic [XW-1:0] lo;

	assign ax = XW'(a_s1);
	assign bx = XW'(b_s1);

	always_ff @(posedge clk) begin
		if (en.s2) begin
			p00_s2 <= XW'(ax[LB-1:0] * bx[LB-1:0]);
			p01_s2 <= XW'(ax[LB-1:0] * bx[XW-1:LB]);
			p10_s2 <= XW'(ax[XW-1:LB] * bx[LB-1:0]);
			p11_s2 <= XW'(ax[XW-1:LB] * bx[XW-1:LB]);
		end
	end

	assign mid = (LB+2)'(p00_s2[XW-1:LB]) + (LB+2)'(p01_s2[LB-1:0])
		+ (LB+2)'(p10_s2[LB-1:0]);

	always_ff @(posedge clk) begin
		if (en.s3) begin
			lo_low_s3 <= p00_s2[LB-1:0];
			mid_s3    <= mid;
			hi_any_s3 <= (|p11_s2) || (|p01_s2[XW-1:LB]) || (|p10_s2[XW-1:LB]);
		end
	end

	assign lo       = {mid_s3[LB-1:0], lo_low_s3};
	assign prod_lo  = lo[W-1:0];
	assign prod_ovf = hi_any_s3 || (|mid_s3[LB+1:LB]) || ((lo >> W) != '0);

endmodule

// ----- hw/rtl/sma_addsub.sv -----
// Signed compare and sign-magnitude add and subtract over two pipeline stages.
module sma_addsub import sma_pkg::*; #(
	parameter int W = DIGIT_COUNT_DEF * DIGIT_BITS_DEF
) (
	input  logic         clk,
	input  stage_en_t    en,
	input  op_t          op_s1,
	input  logic [W-1:0] am_s1,
	input  logic         an_s1,
	input  logic [W-1:0] bm_s1,
	input  logic         bn_s1,
	output logic [W-1:0] sum_mag_s3,
	output logic         sum_neg_s3,
	output logic         sum_ovf_s3,
	output logic         gt_s3,
	output logic         lt_s3,
	output logic         eq_s3
);

	logic         mag_gt;
	logic         mag_eq;
	logic         eq;
	logic         gt;
	logic [W-1:0] am_s2;
	logic [W-1:0] bm_s2;
	logic         an_s2;
	logic         bne_s2;
	logic         mag_ge_s2;
	logic         gt_s2;
	logic         lt_s2;
	logic         eq_s2;
	logic [W:0]   sum;
	logic [W-1:0] diff_ab;
	logic [W-1:0] diff_ba;

	assign mag_gt = am_s1 > bm_s1;
	assign mag_eq = am_s1 == bm_s1;

	always_comb begin
		eq = (an_s1 == bn_s1) && mag_eq;
		if (eq) begin
			gt = 1'b0;
		end else if (an_s1 != bn_s1) begin
			gt = !an_s1;
		end else if (an_s1) begin
			gt = !mag_gt && !mag_eq;
		end else begin
			gt = mag_gt;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			am_s2     <= am_s1;
			bm_s2     <= bm_s1;
			an_s2     <= an_s1;
			bne_s2    <= (op_s1 == OP_SUB) ? !bn_s1 : bn_s1;
			mag_ge_s2 <= mag_gt || mag_eq;
			eq_s2     <= eq;
			gt_s2     <= gt;
			lt_s2     <= !eq && !gt;
		end
	end

	assign sum     = {1'b0, am_s2} + {1'b0, bm_s2};
	assign diff_ab = am_s2 - bm_s2;
	assign diff_ba = bm_s2 - am_s2;

	always_ff @(posedge clk) begin
		if (en.s3) begin
			gt_s3 <= gt_s2;
			lt_s3 <= lt_s2;
			eq_s3 <= eq_s2;
			if (an_s2 == bne_s2) begin
				sum_mag_s3 <= sum[W-1:0];
				sum_neg_s3 <= an_s2;
				sum_ovf_s3 <= sum[W];
			end else if (mag_ge_s2) begin
				sum_mag_s3 <= diff_ab;
				sum_neg_s3 <= an_s2;
				sum_ovf_s3 <= 1'b0;
			end else begin
				sum_mag_s3 <= diff_ba;
				sum_neg_s3 <= bne_s2;
				sum_ovf_s3 <= 1'b0;
			end
		end
	end

endmodule
